>>> hw/rtl/smb_pkg.sv
// Package for the stereo mix biquad filter: widths, register indexes and reset values.
// Used by the top level and its defaults; no dependencies.
package smb_pkg;

    localparam int SMB_SAMPLE_WIDTH   = 16;
    localparam int SMB_COEF_FRAC_BITS = 14;
    localparam int COEF_WIDTH         = 18;
    localparam int NUM_COEFS          = 5;
    localparam int CFG_INDEX_WIDTH    = 3;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COEF_X0 = 3'd0,
        REG_COEF_X1 = 3'd1,
        REG_COEF_X2 = 3'd2,
        REG_COEF_Y1 = 3'd3,
        REG_COEF_Y2 = 3'd4
    } cfg_index_t;

    // 1.0 in Q3.14
    localparam coef_t COEF_X0_RESET = 18'sd16384;
    localparam coef_t COEF_ZERO     = 18'sd0;

endpackage

>>> hw/rtl/smb_if.sv
// Stream interfaces for the stereo mix biquad filter: stereo input words and mono result words.
// Valid/ready handshake; no dependencies.
interface smb_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface smb_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
    logic                           clipped;

    modport source (output valid, output filtered_sample, output clipped, input ready);
    modport sink   (input valid, input filtered_sample, input clipped, output ready);
endinterface

>>> hw/rtl/stereo_mix_biquad_df1.sv
// Top level of the stereo mix biquad filter: stereo-to-mono mix and direct form I biquad.
// Depends on smb_pkg and the smb_in_if / smb_out_if interfaces.
//
// Takes one stereo word per cycle while the mono input register is empty or the output is
// free, halves the sum of the two channels (rounding down) and filters it with a direct form I
// biquad whose five Q3.14 coefficients are written through the cfg port (index 0..4: x0, x1,
// x2, y1, y2; other indexes are ignored). The exact sum is shifted right by COEF_FRAC_BITS
// toward zero and saturated; clipped flags saturation. An accepted word is held in the mono
// input register, which feeds the multiply-accumulate logic; when the output is free, that
// logic loads the output register and the output delay line, closing the feedback loop.
// Write coefficients only while no word is in flight.
module stereo_mix_biquad_df1
    import smb_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SMB_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = SMB_COEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]      cfg_data,
    smb_in_if.sink                     stereo,
    smb_out_if.source                  mono
);

    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 3;
    localparam int HI_WIDTH   = ACC_WIDTH - SAMPLE_WIDTH + 1;

    coef_t coef_x0_reg, coef_x1_reg, coef_x2_reg, coef_y1_reg, coef_y2_reg;

    logic                           mix_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] mix_reg;
    logic signed [SAMPLE_WIDTH-1:0] input_delay_one_reg, input_delay_two_reg;
    logic signed [SAMPLE_WIDTH-1:0] output_delay_one_reg, output_delay_two_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_clipped_reg;

    logic signed [SAMPLE_WIDTH:0]   pair_sum;
    logic signed [SAMPLE_WIDTH-1:0] mix_next;
    logic                           out_free;
    logic                           mix_move;
    logic                           stereo_take;

    logic signed [PROD_WIDTH-1:0]   prod_x0, prod_x1, prod_x2, prod_y1, prod_y2;
    logic signed [ACC_WIDTH-1:0]    acc;
    logic signed [ACC_WIDTH-1:0]    acc_biased;
    logic signed [ACC_WIDTH-1:0]    quot;
    logic [HI_WIDTH-1:0]            quot_hi;
    logic                           clip_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x0_reg <= COEF_X0_RESET;
            coef_x1_reg <= COEF_ZERO;
            coef_x2_reg <= COEF_ZERO;
            coef_y1_reg <= COEF_ZERO;
            coef_y2_reg <= COEF_ZERO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_X0: coef_x0_reg <= cfg_data;
                REG_COEF_X1: coef_x1_reg <= cfg_data;
                REG_COEF_X2: coef_x2_reg <= cfg_data;
                REG_COEF_Y1: coef_y1_reg <= cfg_data;
                REG_COEF_Y2: coef_y2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free     = !out_valid_reg || mono.ready;
    assign mix_move     = mix_valid_reg && out_free;
    assign stereo.ready = !mix_valid_reg || out_free;
    assign stereo_take  = stereo.valid && stereo.ready;

    // mono mix, floor of half the sum
    assign pair_sum = {stereo.left_sample[SAMPLE_WIDTH-1], stereo.left_sample}
                    + {stereo.right_sample[SAMPLE_WIDTH-1], stereo.right_sample};
    assign mix_next = pair_sum[SAMPLE_WIDTH:1];

    // biquad
    always_comb
    begin
        prod_x0    = coef_x0_reg * mix_reg;
        prod_x1    = coef_x1_reg * input_delay_one_reg;
        prod_x2    = coef_x2_reg * input_delay_two_reg;
        prod_y1    = coef_y1_reg * output_delay_one_reg;
        prod_y2    = coef_y2_reg * output_delay_two_reg;
        acc        = ACC_WIDTH'(prod_x0) + ACC_WIDTH'(prod_x1) + ACC_WIDTH'(prod_x2)
                   - ACC_WIDTH'(prod_y1) - ACC_WIDTH'(prod_y2);
        // bias negatives so the arithmetic shift truncates toward zero
        acc_biased = acc + (acc[ACC_WIDTH-1] ? ACC_WIDTH'({COEF_FRAC_BITS{1'b1}})
                                             : ACC_WIDTH'(0));
        quot       = acc_biased >>> COEF_FRAC_BITS;
        quot_hi    = quot[ACC_WIDTH-1:SAMPLE_WIDTH-1];
        clip_next  = !((&quot_hi) || !(|quot_hi));
        if (clip_next)
            sample_next = quot[ACC_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                            : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else
            sample_next = quot[SAMPLE_WIDTH-1:0];
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg        <= 1'b0;
            out_valid_reg        <= 1'b0;
            input_delay_one_reg  <= '0;
            input_delay_two_reg  <= '0;
            output_delay_one_reg <= '0;
            output_delay_two_reg <= '0;
        end
        else
        begin
            if (stereo.ready)
                mix_valid_reg <= stereo.valid;
            if (out_free)
                out_valid_reg <= mix_valid_reg;
            if (mix_move)
            begin
                input_delay_two_reg  <= input_delay_one_reg;
                input_delay_one_reg  <= mix_reg;
                output_delay_two_reg <= output_delay_one_reg;
                output_delay_one_reg <= sample_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (stereo_take)
            mix_reg <= mix_next;
        if (mix_move)
        begin
            out_sample_reg  <= sample_next;
            out_clipped_reg <= clip_next;
        end
    end

    assign mono.valid           = out_valid_reg;
    assign mono.filtered_sample = out_sample_reg;
    assign mono.clipped         = out_clipped_reg;

endmodule

>>> hw/rtl/smb_checker.sv
// Port-level checker for the stereo mix biquad filter, bound to the top level.
// Depends on stereo_mix_biquad_df1 and its interface ports.
module smb_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] out_sample,
    input logic                           out_clipped
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
            inflight_next = inflight_reg + 2'd1;
        else if (out_take && !in_take)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 2'd0;
        else
            inflight_reg <= inflight_next;
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
        else $error("result word changed while stalled");

    // clipped words sit at full scale
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_clipped |->
            out_sample == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} ||
            out_sample == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}})
        else $error("clipped word not at full scale");

    // input backpressure only when the output is full and stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // no more than two words in flight, and no result word without one
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3 && (!out_valid || inflight_reg != 2'd0))
        else $error("word count mismatch between input and output");

endmodule

bind stereo_mix_biquad_df1 smb_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_smb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stereo.valid),
    .in_ready   (stereo.ready),
    .out_valid  (mono.valid),
    .out_ready  (mono.ready),
    .out_sample (mono.filtered_sample),
    .out_clipped(mono.clipped)
);
